[hw/rtl/sle_pkg.sv]
// sle_pkg: shared types and operation codes of the sequential list engine
// no dependencies; imported by sle_cell, sle_reduce, sequential_list_engine, list_checker and tb_top
package sle_pkg;

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_GET    = 3'd2;
	localparam logic [2:0] OP_LOCATE = 3'd3;
	localparam logic [2:0] OP_CLEAR  = 3'd4;

	localparam int POS_W   = 5;
	localparam int WORD_W  = 32;
	localparam int COUNT_W = 5;

	typedef logic signed [WORD_W-1:0] word_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic               en;
		logic               ins;
		logic               del;
		logic               clr;
		logic [POS_W-1:0]   pos_m1;
		word_t              value;
	} cell_ctrl_t;

endpackage

[hw/rtl/sle_cell.sv]
// sle_cell: one list slot holding an entry and its valid bit, shifting with its neighbors
// depends on sle_pkg
module sle_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sle_pkg::cell_ctrl_t ctrl,
	input  sle_pkg::word_t     left_data,
	input  logic               left_vld,
	input  sle_pkg::word_t     right_data,
	input  logic               right_vld,
	output sle_pkg::word_t     data,
	output logic               vld,
	output logic               hit_s1,
	output sle_pkg::word_t     sel_s1
);
	import sle_pkg::*;

	localparam logic [31:0] IDXV = 32'(IDX);

	word_t data_q;
	logic  vld_q;
	word_t nxt_data;
	logic  nxt_vld;
	logic  idx_eq;
	logic  idx_gt;

	assign idx_eq = IDXV == 32'(ctrl.pos_m1);
	assign idx_gt = IDXV > 32'(ctrl.pos_m1);

	always_comb begin
		nxt_data = data_q;
		nxt_vld  = vld_q;
		if (ctrl.clr) begin
			nxt_data = '0;
			nxt_vld  = 1'b0;
		end else if (ctrl.ins) begin
			if (idx_eq) begin
				nxt_data = ctrl.value;
				nxt_vld  = 1'b1;
			end else if (idx_gt) begin
				nxt_data = left_data;
				nxt_vld  = left_vld;
			end
		end else if (ctrl.del) begin
			if (idx_eq || idx_gt) begin
				nxt_data = right_data;
				nxt_vld  = right_vld;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
			vld_q  <= 1'b0;
		end else if (ctrl.en) begin
			data_q <= nxt_data;
			vld_q  <= nxt_vld;
		end
	end

	// compare and select on the contents before the update
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			hit_s1 <= vld_q && (data_q == ctrl.value);
			sel_s1 <= idx_eq ? data_q : '0;
		end
	end

	assign data = data_q;
	assign vld  = vld_q;

endmodule

[hw/rtl/sle_reduce.sv]
// sle_reduce: combines the per-cell match bits and selected words into one result
// depends on sle_pkg
module sle_reduce #(
	parameter int CAPACITY = 16
) (
	input  logic [CAPACITY-1:0]  hit,
	input  sle_pkg::word_t       sel [CAPACITY],
	output logic [sle_pkg::COUNT_W-1:0] found,
	output sle_pkg::word_t       data
);
	import sle_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic [CAPACITY-1:0] first_hit;
	logic [IW-1:0]       enc;
	logic [31:0]         pos1;

	// isolate the lowest set bit
	assign first_hit = hit & (~hit + {{(CAPACITY-1){1'b0}}, 1'b1});

	always_comb begin
		logic [31:0] iv;
		enc = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			iv = 32'(i);
			for (int b = 0; b < IW; b++) begin
				enc[b] = enc[b] | (first_hit[i] & iv[b]);
			end
		end
	end

	assign pos1  = 32'(enc) + 32'd1;
	assign found = (|hit) ? pos1[COUNT_W-1:0] : '0;

	always_comb begin
		data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			data = data | sel[i];
		end
	end

endmodule

[hw/rtl/sequential_list_engine.sv]
// sequential_list_engine: ordered list of signed words in a chain of shifting cells
// depends on sle_pkg, sle_cell, sle_reduce
//
// channel   dir  transaction fields (lowest bit up)
// s_*       in   tuser: func[2:0]; tdata: position[4:0], value[36:5]
// m_*       out  tdata: ok[0], data_out[32:1], found_position[37:33], count[42:38]
//
// each item: the cells shift and compare at acceptance, then the reduce step
// folds match and select bits into the output register
// s_tready drops during the reduce step, and also while a finished result
// waits for m_tready with the output register still full
// reset empties the list and leaves no result pending
module sequential_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // position, value
	input  logic [2:0]  s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // ok, data_out, found_position, count
);
	import sle_pkg::*;

	localparam int LW = $clog2(CAPACITY + 1);

	logic [2:0]         func;
	logic [POS_W-1:0]   position;
	word_t              value;
	logic               acc;
	logic [31:0]        pos32;
	logic [31:0]        len32;
	logic               ins_ok;
	logic               rd_ok;
	logic               op_ok;
	logic [LW-1:0]      len_q;
	logic [LW-1:0]      len_d;
	logic [31:0]        len_d32;
	cell_ctrl_t         ctrl;

	logic               fin_q;
	logic               ok_s1;
	logic               dsel_s1;
	logic               loc_s1;
	logic [COUNT_W-1:0] count_s1;

	word_t              cdata [CAPACITY];
	logic               cvld  [CAPACITY];
	logic [CAPACITY-1:0] hit_s1;
	word_t              sel_s1 [CAPACITY];

	logic [COUNT_W-1:0] red_found;
	word_t              red_data;
	logic               ld;
	logic               m_tvalid_q;
	logic [47:0]        m_tdata_q;

	assign func     = s_tuser;
	assign position = s_tdata[POS_W-1:0];
	assign value    = s_tdata[POS_W+WORD_W-1:POS_W];

	assign s_tready = !fin_q;
	assign acc      = s_tvalid && s_tready;

	assign pos32  = 32'(position);
	assign len32  = 32'(len_q);
	assign ins_ok = (pos32 != 32'd0) && (pos32 <= len32 + 32'd1) && (len32 < 32'(CAPACITY));
	assign rd_ok  = (pos32 != 32'd0) && (pos32 <= len32);

	always_comb begin
		op_ok = 1'b0;
		len_d = len_q;
		case (func)
			OP_INSERT: begin
				op_ok = ins_ok;
				if (ins_ok) len_d = len_q + LW'(1);
			end
			OP_DELETE: begin
				op_ok = rd_ok;
				if (rd_ok) len_d = len_q - LW'(1);
			end
			OP_GET:    op_ok = rd_ok;
			OP_LOCATE: op_ok = 1'b1;
			OP_CLEAR: begin
				op_ok = 1'b1;
				len_d = '0;
			end
			default:   op_ok = 1'b0;
		endcase
	end

	assign len_d32 = 32'(len_d);

	assign ctrl.en     = acc;
	assign ctrl.ins    = acc && (func == OP_INSERT) && ins_ok;
	assign ctrl.del    = acc && (func == OP_DELETE) && rd_ok;
	assign ctrl.clr    = acc && (func == OP_CLEAR);
	assign ctrl.pos_m1 = position - POS_W'(1);
	assign ctrl.value  = value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		word_t ld_data;
		logic  ld_vld;
		word_t rd_data;
		logic  rd_vld;

		if (i == 0) begin : g_first
			assign ld_data = '0;
			assign ld_vld  = 1'b0;
		end else begin : g_mid
			assign ld_data = cdata[i-1];
			assign ld_vld  = cvld[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign rd_data = '0;
			assign rd_vld  = 1'b0;
		end else begin : g_inner
			assign rd_data = cdata[i+1];
			assign rd_vld  = cvld[i+1];
		end

		sle_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.left_data  (ld_data),
			.left_vld   (ld_vld),
			.right_data (rd_data),
			.right_vld  (rd_vld),
			.data       (cdata[i]),
			.vld        (cvld[i]),
			.hit_s1     (hit_s1[i]),
			.sel_s1     (sel_s1[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (acc) begin
			len_q <= len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= 1'b0;
		end else if (acc) begin
			fin_q <= 1'b1;
		end else if (ld) begin
			fin_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ok_s1    <= op_ok;
			dsel_s1  <= op_ok && ((func == OP_GET) || (func == OP_DELETE));
			loc_s1   <= func == OP_LOCATE;
			count_s1 <= len_d32[COUNT_W-1:0];
		end
	end

	sle_reduce #(
		.CAPACITY(CAPACITY)
	) u_reduce (
		.hit   (hit_s1),
		.sel   (sel_s1),
		.found (red_found),
		.data  (red_data)
	);

	assign ld = fin_q && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			m_tdata_q <= {
				5'b0,
				count_s1,
				loc_s1 ? red_found : {COUNT_W{1'b0}},
				dsel_s1 ? red_data : word_t'(0),
				ok_s1
			};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[tb/list_checker.sv]
`timescale 1ns / 1ps
// list_checker: watches both channels of sequential_list_engine, keeps its own copy of the
// list, predicts every response and compares it field by field; depends on sle_pkg
module list_checker #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // position, value
	input  logic [2:0]  s_tuser,   // func
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // ok, data_out, found_position, count
	output int          fail_count,
	output int          pending,
	output int          checked
);
	import sle_pkg::*;

	typedef struct packed {
		logic               ok;
		word_t              data;
		logic [POS_W-1:0]   found;
		logic [COUNT_W-1:0] count;
	} list_reply_t;

	word_t       list_mem [CAPACITY];
	int          list_len;
	list_reply_t reply_q [$];

	function automatic void clear_list();
		for (int k = 0; k < CAPACITY; k++)
			list_mem[k] = '0;
		list_len = 0;
	endfunction

	function automatic list_reply_t apply_request(logic [2:0] func, logic [POS_W-1:0] pos,
			word_t val);
		list_reply_t r;
		int p;
		r = '0;
		p = int'(pos);
		case (func)
			OP_INSERT: begin
				if (p >= 1 && p <= list_len + 1 && list_len < CAPACITY) begin
					for (int k = list_len; k >= p; k--)
						list_mem[k] = list_mem[k - 1];
					list_mem[p - 1] = val;
					list_len++;
					r.ok = 1'b1;
				end
			end
			OP_DELETE: begin
				if (p >= 1 && p <= list_len) begin
					r.data = list_mem[p - 1];
					for (int k = p; k < list_len; k++)
						list_mem[k - 1] = list_mem[k];
					list_mem[list_len - 1] = '0;
					list_len--;
					r.ok = 1'b1;
				end
			end
			OP_GET: begin
				if (p >= 1 && p <= list_len) begin
					r.data = list_mem[p - 1];
					r.ok = 1'b1;
				end
			end
			OP_LOCATE: begin
				for (int k = 0; k < list_len; k++) begin
					if (r.found == '0 && list_mem[k] == val)
						r.found = POS_W'(k + 1);
				end
				r.ok = 1'b1;
			end
			OP_CLEAR: begin
				clear_list();
				r.ok = 1'b1;
			end
			default: begin
			end
		endcase
		r.count = COUNT_W'(list_len);
		return r;
	endfunction

	function automatic int field_differs(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_reply_t want;
		list_reply_t got;
		if (!arst_n) begin
			clear_list();
			reply_q.delete();
			pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				reply_q.push_back(apply_request(s_tuser, s_tdata[4:0], s_tdata[36:5]));
			if (m_tvalid && m_tready) begin
				got = {m_tdata[0], m_tdata[32:1], m_tdata[37:33], m_tdata[42:38]};
				if (reply_q.size() == 0) begin
					$display("%0t: response with no request outstanding, expected none, actual %h",
						$time, m_tdata);
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					checked++;
					fail_count += field_differs("ok", want.ok, got.ok);
					fail_count += field_differs("data_out", want.data, got.data);
					fail_count += field_differs("found_position", want.found, got.found);
					fail_count += field_differs("count", want.count, got.count);
				end
			end
			pending = reply_q.size();
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: clock, reset, request stimulus, response back-pressure and verdict for
// sequential_list_engine; depends on sle_pkg, sequential_list_engine and list_checker
module tb_top;
	import sle_pkg::*;

	localparam int         CAPACITY     = 16;
	localparam logic [2:0] FUNC_LAST    = 3'd7;
	localparam int         POS_LAST     = (1 << POS_W) - 1;
	localparam int         RANDOM_ITEMS = 650;
	localparam int         QUIET_TAIL   = 100;
	localparam int         HOLD_AFTER   = 150;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         DRAIN_LIMIT  = 5000;
	localparam int         LIMIT_NS     = 400_000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;

	int    fail_count;
	int    pending;
	int    checked;
	int    items_sent = 0;
	int    list_fill = 0;
	int    op_tally [8] = '{default: 0};
	bit    tx_idle = 1'b0;
	bit    rx_idle = 1'b0;
	bit    held_off = 1'b0;
	word_t recent [8] = '{default: '0};

	sequential_list_engine #(.CAPACITY(CAPACITY)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	list_checker #(.CAPACITY(CAPACITY)) reply_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	always #1 clk = ~clk;

	initial begin
		#(LIMIT_NS);
		$display("TB_ERROR");
		$finish;
	end

	task automatic send(logic [2:0] func, logic [POS_W-1:0] pos, word_t val);
		s_tuser <= func;
		s_tdata <= {3'b000, val, pos};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		op_tally[func]++;
		case (func)
			OP_INSERT: begin
				if (pos >= 1 && int'(pos) <= list_fill + 1 && list_fill < CAPACITY) begin
					list_fill++;
					recent[3'(items_sent)] = val;
				end
			end
			OP_DELETE: if (pos >= 1 && int'(pos) <= list_fill) list_fill--;
			OP_CLEAR: list_fill = 0;
			default: begin
			end
		endcase
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	function automatic word_t pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3: return recent[3'($urandom_range(0, 7))];
			4: return word_t'($urandom_range(0, 3));
			default: return word_t'($urandom());
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		return POS_W'($urandom_range(1, list_fill > 0 ? list_fill : 1));
	endfunction

	task automatic random_item();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 38)
			send(OP_INSERT, POS_W'($urandom_range(1, list_fill + 1)), pick_value());
		else if (roll < 53)
			send(OP_DELETE, pick_position(), pick_value());
		else if (roll < 67)
			send(OP_GET, pick_position(), pick_value());
		else if (roll < 80)
			send(OP_LOCATE, POS_W'($urandom_range(0, POS_LAST)), pick_value());
		else if (roll < 93)
			send(3'($urandom_range(0, FUNC_LAST)), POS_W'($urandom_range(0, POS_LAST)),
				word_t'($urandom()));
		else if (roll < 96)
			send(OP_CLEAR, POS_W'($urandom_range(0, POS_LAST)), word_t'($urandom()));
		else begin
			// refill from empty, with inserts beyond capacity
			send(OP_CLEAR, '0, '0);
			repeat (CAPACITY + 2)
				send(OP_INSERT, POS_W'($urandom_range(1, list_fill + 1)), pick_value());
		end
	endtask

	// response side back-pressure
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_off && items_sent >= HOLD_AFTER) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int base;
		int guard;
		int unused;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_INSERT;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, bounds, extremes, middle and last positions, unused codes
		send(OP_GET, POS_W'(1), '0);
		send(OP_DELETE, POS_W'(1), '0);
		send(OP_LOCATE, POS_W'(0), '0);
		send(OP_INSERT, POS_W'(0), 5);
		send(OP_INSERT, POS_W'(2), 5);
		send(OP_INSERT, POS_W'(1), 32'h8000_0000);
		send(OP_INSERT, POS_W'(2), 32'h7fff_ffff);
		send(OP_INSERT, POS_W'(1), -1);
		send(OP_INSERT, POS_W'(3), '0);
		send(OP_INSERT, POS_W'(POS_LAST), 1);
		send(OP_LOCATE, POS_W'(0), 32'h7fff_ffff);
		send(OP_LOCATE, POS_W'(POS_LAST), '0);
		send(OP_LOCATE, POS_W'(0), 12345);
		send(OP_GET, POS_W'(4), '0);
		send(OP_GET, POS_W'(5), '0);
		send(OP_GET, POS_W'(POS_LAST), '0);
		send(OP_DELETE, POS_W'(5), '0);
		send(OP_DELETE, POS_W'(2), '0);
		send(OP_DELETE, POS_W'(3), '0);
		send(OP_GET, POS_W'(3), '0);
		for (int f = int'(OP_CLEAR) + 1; f <= int'(FUNC_LAST); f++)
			send(3'(f), POS_W'(1), -1);
		send(OP_CLEAR, POS_W'(0), '0);
		send(OP_GET, POS_W'(1), '0);

		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			if (items_sent - base >= RANDOM_ITEMS - QUIET_TAIL) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end else if ($urandom_range(0, 39) == 0) begin
				tx_idle = $urandom_range(0, 1);
				rx_idle = $urandom_range(0, 1);
			end
			random_item();
		end
		s_tvalid <= 1'b0;

		guard = 0;
		while (pending != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);

		if (pending != 0)
			$display("%0t: %0d responses never arrived", $time, pending);
		unused = items_sent - op_tally[OP_INSERT] - op_tally[OP_DELETE] - op_tally[OP_GET]
			- op_tally[OP_LOCATE] - op_tally[OP_CLEAR];
		$display("requests: %0d insert, %0d delete, %0d get, %0d locate, %0d clear, %0d unused code",
			op_tally[OP_INSERT], op_tally[OP_DELETE], op_tally[OP_GET], op_tally[OP_LOCATE],
			op_tally[OP_CLEAR], unused);
		$display("%0d responses compared, one long response stall of %0d cycles",
			checked, HOLD_CYCLES);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
